// ===== rtl/geo_pkg.sv =====
// Shared types and constants for the polygon geofence checker.
`timescale 1ns / 1ps

package geo_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int LON_W = 29;
  localparam int LAT_W = 28;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTER_EN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAVE_EN     = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TEST  = 1'b1;

  localparam logic [1:0] EVT_NONE  = 2'd0;
  localparam logic [1:0] EVT_ENTER = 2'd1;
  localparam logic [1:0] EVT_LEAVE = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_FINISH
  } geo_state_t;

  // One edge presented to the crossing unit.
  typedef struct packed {
    logic                    valid;
    logic signed [LON_W-1:0] x1;
    logic signed [LAT_W-1:0] y1;
    logic signed [LON_W-1:0] x2;
    logic signed [LAT_W-1:0] y2;
    logic signed [LON_W-1:0] px;
    logic signed [LAT_W-1:0] py;
  } geo_edge_t;

  // Crossing verdict for one edge.
  typedef struct packed {
    logic valid;
    logic hit;
  } geo_hit_t;

endpackage

// ===== rtl/geo_cell.sv =====
// One vertex cell of the rotating vertex ring.
`timescale 1ns / 1ps

module geo_cell
  import geo_pkg::*;
(
  input  logic                    clk,
  input  logic                    load,
  input  logic                    shift,
  input  logic signed [LON_W-1:0] wr_lon,
  input  logic signed [LAT_W-1:0] wr_lat,
  input  logic signed [LON_W-1:0] nbr_lon,
  input  logic signed [LAT_W-1:0] nbr_lat,
  output logic signed [LON_W-1:0] lon,
  output logic signed [LAT_W-1:0] lat
);

  logic signed [LON_W-1:0] lon_r, lon_nxt;
  logic signed [LAT_W-1:0] lat_r, lat_nxt;

  always_comb begin
    lon_nxt = lon_r;
    lat_nxt = lat_r;
    if (load) begin
      lon_nxt = wr_lon;
      lat_nxt = wr_lat;
    end else if (shift) begin
      lon_nxt = nbr_lon;
      lat_nxt = nbr_lat;
    end
  end

  always_ff @(posedge clk) begin
    lon_r <= lon_nxt;
    lat_r <= lat_nxt;
  end

  assign lon = lon_r;
  assign lat = lat_r;

endmodule

// ===== rtl/geo_edge_unit.sv =====
// Pipelined exact ray crossing test for one edge per cycle.
`timescale 1ns / 1ps

module geo_edge_unit
  import geo_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  geo_edge_t edge_in,
  output geo_hit_t  hit_out
);

  localparam int PW = LON_W + LAT_W + 2;

  logic                    v1_r, v1_nxt;
  logic                    dpos1_r, dpos1_nxt;
  logic signed [LON_W:0]   dxp_r, dxp_nxt;
  logic signed [LON_W:0]   dx_r, dx_nxt;
  logic signed [LAT_W:0]   d_r, d_nxt;
  logic signed [LAT_W:0]   dyp_r, dyp_nxt;

  logic                    v2_r;
  logic                    dpos2_r;
  logic signed [PW-1:0]    lhs_r, rhs_r;

  logic signed [LAT_W-1:0] ymax, ymin;
  logic signed [LON_W-1:0] xmax;
  logic                    skip;

  // Stage 1: span test and differences.
  always_comb begin
    ymax = (edge_in.y1 > edge_in.y2) ? edge_in.y1 : edge_in.y2;
    ymin = (edge_in.y1 < edge_in.y2) ? edge_in.y1 : edge_in.y2;
    xmax = (edge_in.x1 > edge_in.x2) ? edge_in.x1 : edge_in.x2;
    skip = (edge_in.py >= ymax) || (edge_in.py <= ymin) || (edge_in.px > xmax);
    v1_nxt    = edge_in.valid && !skip;
    dxp_nxt   = (LON_W+1)'(edge_in.x1) - (LON_W+1)'(edge_in.px);
    dx_nxt    = (LON_W+1)'(edge_in.x1) - (LON_W+1)'(edge_in.x2);
    d_nxt     = (LAT_W+1)'(edge_in.y1) - (LAT_W+1)'(edge_in.y2);
    dyp_nxt   = (LAT_W+1)'(edge_in.y1) - (LAT_W+1)'(edge_in.py);
    dpos1_nxt = edge_in.y1 > edge_in.y2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v1_r;
    end
    dxp_r   <= dxp_nxt;
    dx_r    <= dx_nxt;
    d_r     <= d_nxt;
    dyp_r   <= dyp_nxt;
    dpos1_r <= dpos1_nxt;
    // Stage 2: cross products.
    lhs_r   <= PW'(dxp_r) * PW'(d_r);
    rhs_r   <= PW'(dx_r) * PW'(dyp_r);
    dpos2_r <= dpos1_r;
  end

  // Stage 3: signed compare of the registered products.
  always_comb begin
    hit_out.valid = v2_r;
    hit_out.hit   = dpos2_r ? (lhs_r > rhs_r) : (lhs_r < rhs_r);
  end

endmodule

// ===== rtl/polygon_geofence_checker.sv =====
// Top level of the polygon geofence checker: vertex ring, edge walk and event logic.
//
// Usage:
//   Input channel: present in_cmd, in_vertex_index, in_longitude, in_latitude
//   with start high; the transaction is taken at a rising edge where busy is low.
//   A vertex write (in_cmd 0) lands in its ring cell at that edge, does not raise
//   busy and gives no result; slots at or above MAX_VERTICES are dropped.
//   A point test (in_cmd 1) raises busy until its result is out. The ring of vertex
//   cells rotates one place per cycle, so one edge enters the three-stage crossing
//   unit each cycle; the full rotation puts every vertex back in its slot. The
//   result strobes out_valid for one cycle, in the cycle busy falls, so a new test
//   can be taken only once the previous result is out.
//   The receiver cannot stall: out_valid lasts exactly one cycle.
//   Config channel: cfg_ready is always high; write cfg_index / cfg_data only
//   while busy is low. Index 0 vertex count, 1 enter alarm enable, 2 leave alarm
//   enable; other indexes are ignored.
//   Reset (rst_n low, synchronous) clears control, the in-area flag and the
//   config registers to count 4 with both alarms enabled. Vertex cells are not
//   cleared; a test must use only written vertices.
`timescale 1ns / 1ps

module polygon_geofence_checker
  import geo_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_cmd,
  input  logic [IDX_W-1:0]             in_vertex_index,
  input  logic signed [LON_W-1:0]      in_longitude,
  input  logic signed [LAT_W-1:0]      in_latitude,
  output logic                         out_valid,
  output logic                         out_inside_res,
  output logic [1:0]                   out_area_event,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int KW = $clog2(MAX_VERTICES + 1);
  localparam int SW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam logic [KW-1:0] K_LAST = KW'(MAX_VERTICES);

  // Config registers.
  logic [CNT_W-1:0] vcount_r;
  logic             enter_en_r, leave_en_r;

  // Control.
  geo_state_t       state_r, state_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic             drain_r, drain_nxt;
  logic             parity_r, parity_nxt;
  logic             flag_r, flag_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_inside_r, out_inside_nxt;
  logic [1:0]       out_event_r, out_event_nxt;

  // Captured test point and walk registers.
  logic signed [LON_W-1:0] px_r, first_lon_r, prev_lon_r;
  logic signed [LAT_W-1:0] py_r, first_lat_r, prev_lat_r;

  logic signed [LON_W-1:0] cell_lon [MAX_VERTICES];
  logic signed [LAT_W-1:0] cell_lat [MAX_VERTICES];

  logic             accept, wr_en, test_go, shift;
  logic [SW-1:0]    wr_slot;
  logic [KW-1:0]    n_eff;
  geo_edge_t        edge_req;
  geo_hit_t         edge_hit;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign wr_en     = accept && (in_cmd == CMD_WRITE) &&
                     (32'(in_vertex_index) < MAX_VERTICES);
  assign test_go   = accept && (in_cmd == CMD_TEST);
  assign wr_slot   = SW'(in_vertex_index);
  assign n_eff     = (32'(vcount_r) > MAX_VERTICES) ? K_LAST : KW'(vcount_r);
  // Rotate the ring once per step; the final step leaves it in place.
  assign shift     = (state_r == S_WALK) && (k_r != K_LAST);

  // Vertex ring: cell i takes cell i+1, the last cell takes cell 0.
  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    geo_cell u_cell (
      .clk     (clk),
      .load    (wr_en && (wr_slot == SW'(i))),
      .shift   (shift),
      .wr_lon  (in_longitude),
      .wr_lat  (in_latitude),
      .nbr_lon (cell_lon[(i + 1) % MAX_VERTICES]),
      .nbr_lat (cell_lat[(i + 1) % MAX_VERTICES]),
      .lon     (cell_lon[i]),
      .lat     (cell_lat[i])
    );
  end

  // Step k shows vertex k in cell 0. Steps 1..n-1 test edge (k-1, k); step n
  // closes the polygon with edge (n-1, 0) from the saved first vertex.
  always_comb begin
    edge_req.valid = (state_r == S_WALK) && (k_r != '0) && (k_r <= n_eff);
    edge_req.x1    = prev_lon_r;
    edge_req.y1    = prev_lat_r;
    edge_req.x2    = (k_r == n_eff) ? first_lon_r : cell_lon[0];
    edge_req.y2    = (k_r == n_eff) ? first_lat_r : cell_lat[0];
    edge_req.px    = px_r;
    edge_req.py    = py_r;
  end

  geo_edge_unit u_edge (
    .clk     (clk),
    .rst_n   (rst_n),
    .edge_in (edge_req),
    .hit_out (edge_hit)
  );

  // Sequencer: walk, drain the crossing pipeline, then report.
  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    drain_nxt      = drain_r;
    parity_nxt     = parity_r ^ (edge_hit.valid && edge_hit.hit);
    flag_nxt       = flag_r;
    out_valid_nxt  = 1'b0;
    out_inside_nxt = out_inside_r;
    out_event_nxt  = out_event_r;
    busy           = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (test_go) begin
          state_nxt  = S_WALK;
          k_nxt      = '0;
          parity_nxt = 1'b0;
        end
      end
      S_WALK: begin
        if (k_r == K_LAST) begin
          state_nxt = S_DRAIN;
          drain_nxt = 1'b0;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      S_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        out_inside_nxt = parity_r;
        out_event_nxt  = EVT_NONE;
        if (parity_r && enter_en_r) begin
          if (!flag_r) begin
            out_event_nxt = EVT_ENTER;
            flag_nxt      = 1'b1;
          end
        end else if (flag_r) begin
          if (leave_en_r) out_event_nxt = EVT_LEAVE;
          flag_nxt = 1'b0;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      drain_r     <= 1'b0;
      parity_r    <= 1'b0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      drain_r     <= drain_nxt;
      parity_r    <= parity_nxt;
      flag_r      <= flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: hold the result outputs, capture the point, track previous and first vertex.
  always_ff @(posedge clk) begin
    out_inside_r <= out_inside_nxt;
    out_event_r  <= out_event_nxt;
    if (test_go) begin
      px_r <= in_longitude;
      py_r <= in_latitude;
    end
    if (state_r == S_WALK) begin
      prev_lon_r <= cell_lon[0];
      prev_lat_r <= cell_lat[0];
      if (k_r == '0) begin
        first_lon_r <= cell_lon[0];
        first_lat_r <= cell_lat[0];
      end
    end
  end

  // Config writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r   <= CNT_W'(4);
      enter_en_r <= 1'b1;
      leave_en_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_VERTEX_COUNT: vcount_r   <= cfg_data[CNT_W-1:0];
        CFG_ENTER_EN:     enter_en_r <= cfg_data[0];
        CFG_LEAVE_EN:     leave_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;
  assign out_area_event = out_event_r;

endmodule

// ===== rtl/geo_checker.sv =====
// Port-level assertions for the polygon geofence checker, with its bind.
`timescale 1ns / 1ps

module geo_checker
  import geo_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       in_cmd,
  input logic       out_valid,
  input logic       out_inside_res,
  input logic [1:0] out_area_event
);

  // A result closes a test that kept the block busy.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a preceding test");

  a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_area_event == EVT_NONE) || (out_area_event == EVT_ENTER) ||
                   (out_area_event == EVT_LEAVE)))
    else $error("undefined area event code");

  a_enter_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_area_event == EVT_ENTER)) |-> out_inside_res)
    else $error("enter event for a point outside");

  a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_cmd == CMD_WRITE)) |=> !busy)
    else $error("vertex write made the block busy");

endmodule

bind polygon_geofence_checker geo_checker u_geo_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_cmd         (in_cmd),
  .out_valid      (out_valid),
  .out_inside_res (out_inside_res),
  .out_area_event (out_area_event)
);
